@@ src/send_overshoot_ratio_window_top_assert.svh @@
// Assertion macros for the send overshoot ratio window block.
`ifndef SEND_OVERSHOOT_RATIO_WINDOW_TOP_ASSERT_SVH
`define SEND_OVERSHOOT_RATIO_WINDOW_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SORW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorw assertion failed");
`define SORW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sorw assertion failed");
`else
`define SORW_ASSERT(lbl, clk, rstn, prop)
`define SORW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/sorw_pkg.sv @@
// Types and constants shared by the send overshoot ratio window block.
package sorw_pkg;
  localparam logic [15:0] SPAN_RESET = 16'd200;
  localparam logic [9:0]  CAP_RESET  = 10'd150;
  localparam logic [63:0] BYTE_SCALE = 64'd8000;
  localparam logic [27:0] RATIO_NUM  = 28'd204800000;
  localparam int          Q_BITS     = 19;
  localparam logic        REG_SPAN   = 1'b0;
  localparam logic        REG_CAP    = 1'b1;

  typedef struct packed {
    logic [31:0] sequence_number;
    logic [31:0] departure_ms;
    logic [47:0] bytes_sent_total;
    logic [31:0] target_rate_bps;
  } item_t;

  typedef struct packed {
    logic [17:0] overshoot_ratio_q8;
    logic        ratio_updated;
  } result_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] departure_ms;
    logic [47:0] bytes_sent_total;
    logic [31:0] target_rate_bps;
  } work_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [47:0] bytes;
    logic [31:0] rate;
  } entry_t;

  typedef struct packed {
    logic [15:0] span_ms;
    logic [9:0]  cap_pct;
  } cfg_t;
endpackage

@@ src/sorw_front.sv @@
// Front end: accepts records and marks those with a new sequence number.
module sorw_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  sorw_pkg::item_t in_word,
  output logic           in_full,
  input  logic           q_full,
  output logic           q_push,
  output sorw_pkg::work_t q_word
);
  import sorw_pkg::*;

  logic [31:0] newest_r, newest_nxt;
  logic        fresh;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign fresh   = in_word.sequence_number > newest_r;
  assign newest_nxt = (q_push && fresh) ? in_word.sequence_number : newest_r;

  always_comb begin
    q_word.accepted         = fresh;
    q_word.departure_ms     = in_word.departure_ms;
    q_word.bytes_sent_total = in_word.bytes_sent_total;
    q_word.target_rate_bps  = in_word.target_rate_bps;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
    end else begin
      newest_r <= newest_nxt;
    end
  end
endmodule

@@ src/sorw_queue.sv @@
// Two-word queue between front and back.
module sorw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sorw_pkg::work_t push_word,
  output logic            full,
  input  logic            pop,
  output sorw_pkg::work_t pop_word,
  output logic            empty
);
  import sorw_pkg::*;

  work_t       slot_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = slot_r[rptr_r];
  assign cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ src/sorw_back.sv @@
// Back end: window store, running sum, ratio divider and result register.
module sorw_back #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sorw_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  sorw_pkg::work_t   q_word,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output sorw_pkg::result_t out_word
);
  import sorw_pkg::*;
  `include "send_overshoot_ratio_window_top_assert.svh"

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(WINDOW_DEPTH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DRD  = 4'd1;
  localparam logic [3:0] S_DMUL = 4'd2;
  localparam logic [3:0] S_DSUB = 4'd3;
  localparam logic [3:0] S_INS  = 4'd4;
  localparam logic [3:0] S_IADD = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_ML   = 4'd7;
  localparam logic [3:0] S_MH   = 4'd8;
  localparam logic [3:0] S_DIV0 = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_CAP  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  entry_t        mem [WINDOW_DEPTH];
  entry_t        rd_r;
  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_inc, wr_ix;
  logic [CW-1:0] count_r;
  logic [CW:0]   slot_sum;
  logic [63:0]   sum_r, prod_r;
  logic [31:0]   old_time_r, new_time_r, w_time_r, w_rate_r, t_clamp, dt;
  logic [47:0]   old_bytes_r, new_bytes_r, w_bytes_r, sent;
  logic          w_acc_r, full_drop_r;
  logic [51:0]   mlo_r, mhi_r;
  logic [81:0]   rem_r, dsh_r;
  logic [18:0]   q_r;
  logic [4:0]    step_r;
  logic [17:0]   last_ratio_r, q_sat, cap_q8;
  logic          ge, out_free;
  result_t       res_r;
  logic          res_valid_r;

  assign head_inc = (head_r == LAST_IX) ? '0 : head_r + 1'b1;
  assign slot_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign wr_ix    = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : AW'(slot_sum);
  assign t_clamp  = (count_r != '0 && w_time_r < new_time_r) ? new_time_r : w_time_r;
  assign dt       = (count_r != '0) ? t_clamp - new_time_r : 32'd0;
  assign sent     = (new_bytes_r >= old_bytes_r) ? new_bytes_r - old_bytes_r : 48'd0;
  assign ge       = rem_r >= dsh_r;
  assign q_sat    = q_r[18] ? '1 : q_r[17:0];
  assign cap_q8   = {cfg.cap_pct, 8'd0};
  assign out_free = !res_valid_r || out_pop;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !res_valid_r;
  assign out_word  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) begin
        if (!q_word.accepted) state_nxt = S_OUT;
        else if (count_r == CW'(WINDOW_DEPTH)) state_nxt = S_DRD;
        else state_nxt = S_INS;
      end
      S_DRD:  state_nxt = S_DMUL;
      S_DMUL: state_nxt = S_DSUB;
      S_DSUB: state_nxt = full_drop_r ? S_INS : S_CHK;
      S_INS:  state_nxt = S_IADD;
      S_IADD: state_nxt = S_CHK;
      S_CHK: begin
        if (count_r > CW'(1) && (w_time_r - old_time_r) > {16'd0, cfg.span_ms})
          state_nxt = S_DRD;
        else
          state_nxt = S_ML;
      end
      S_ML:   state_nxt = S_MH;
      S_MH:   state_nxt = S_DIV0;
      S_DIV0: state_nxt = S_DIV;
      S_DIV:  state_nxt = (step_r == 5'd0) ? S_CAP : S_DIV;
      S_CAP:  state_nxt = S_OUT;
      S_OUT:  state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // window store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_INS) begin
      mem[wr_ix] <= '{time_ms: t_clamp, bytes: w_bytes_r, rate: w_rate_r};
    end
    rd_r <= mem[head_inc];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        w_acc_r   <= q_word.accepted;
        w_time_r  <= q_word.departure_ms;
        w_bytes_r <= q_word.bytes_sent_total;
        w_rate_r  <= q_word.target_rate_bps;
      end
      S_DMUL: begin
        prod_r      <= 64'(rd_r.rate) * 64'(rd_r.time_ms - old_time_r);
        old_time_r  <= rd_r.time_ms;
        old_bytes_r <= rd_r.bytes;
      end
      S_INS: begin
        prod_r      <= 64'(w_rate_r) * 64'(dt);
        w_time_r    <= t_clamp;
        new_time_r  <= t_clamp;
        new_bytes_r <= w_bytes_r;
        if (count_r == '0) begin
          old_time_r  <= t_clamp;
          old_bytes_r <= w_bytes_r;
        end
      end
      S_ML: mlo_r <= 52'(sent[23:0]) * 52'(RATIO_NUM);
      S_MH: mhi_r <= 52'(sent[47:24]) * 52'(RATIO_NUM);
      S_DIV0: begin
        rem_r  <= (82'(mhi_r) << 24) + 82'(mlo_r);
        dsh_r  <= {sum_r + BYTE_SCALE, 18'd0};
        q_r    <= '0;
        step_r <= 5'(Q_BITS - 1);
      end
      S_DIV: begin
        if (ge) rem_r <= rem_r - dsh_r;
        dsh_r  <= dsh_r >> 1;
        q_r    <= {q_r[17:0], ge};
        step_r <= step_r - 5'd1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      full_drop_r  <= 1'b0;
      last_ratio_r <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: full_drop_r <= !q_empty && q_word.accepted &&
                               count_r == CW'(WINDOW_DEPTH);
        S_DMUL: begin
          head_r  <= head_inc;
          count_r <= count_r - 1'b1;
        end
        S_DSUB: sum_r <= (count_r <= CW'(1)) ? 64'd0 : sum_r - prod_r;
        S_INS: begin
          count_r     <= count_r + 1'b1;
          full_drop_r <= 1'b0;
        end
        S_IADD: sum_r <= sum_r + prod_r;
        S_CAP:  last_ratio_r <= (q_sat < cap_q8) ? q_sat : cap_q8;
        default: ;
      endcase
      if (state_r == S_OUT && out_free) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      res_r.overshoot_ratio_q8 <= last_ratio_r;
      res_r.ratio_updated      <= w_acc_r;
    end
  end

  // when the count drops to one or below in S_DMUL, the sum is cleared in the cycle after, in S_DSUB
  `SORW_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(WINDOW_DEPTH))
  `SORW_ASSERT(a_ins_room, clk, rst_n, (state_r == S_INS) |-> (count_r < CW'(WINDOW_DEPTH)))
  `SORW_ASSERT(a_empty_sum, clk, rst_n, (count_r <= CW'(1) && state_r != S_DSUB) |-> (sum_r == 64'd0))
  `SORW_ASSERT(a_out_done, clk, rst_n, (state_r == S_OUT && out_free) |=> !out_empty)
endmodule

@@ src/send_overshoot_ratio_window_top.sv @@
// Top level of the send overshoot ratio window block.
// Usage:
//  - Input queue: present a feedback word on in_word with in_push; it is taken
//    when in_full is low. Only words whose sequence number beats the newest
//    one seen enter the window; others still produce one result word.
//  - Result queue: while out_empty is low, out_word holds the oldest result;
//    raise out_pop to take it. Every input word yields exactly one result.
//  - Config: cfg_we with cfg_index (0 = window span in ms, 1 = ratio cap in
//    percent) and cfg_wdata; write only while the block is idle.
//  - Sequence: a repeated sequence number goes straight to the result stage; a
//    new record first drops the oldest one if the store is full, is inserted,
//    drops old records as the window slides, then the ratio is multiplied, run
//    through the 19-step divider and capped; drops use the store's single read port.
//  - Flow: the back end handles one record at a time and takes the next only
//    from idle; a two-word queue lets the front keep accepting.
//  - Reset (rst_n low, synchronous): window empties, sum and newest sequence
//    clear, last ratio reads zero, span 200 ms, cap 150 percent. No clearing
//    pass: the store is only read at entries that were written.
//  - If the receiver stalls, the result register holds and the back end waits
//    with its next result; the queue then fills and in_full rises.
module send_overshoot_ratio_window_top #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  sorw_pkg::item_t   in_word,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output sorw_pkg::result_t out_word,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import sorw_pkg::*;

  cfg_t  cfg_r;
  work_t fq_word, bq_word;
  logic  fq_push, fq_full, bq_pop, bq_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span_ms <= SPAN_RESET;
      cfg_r.cap_pct <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAN: cfg_r.span_ms <= cfg_wdata;
        REG_CAP:  cfg_r.cap_pct <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // front: sequence filter
  sorw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_word  (fq_word)
  );

  // decoupling queue
  sorw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_word (fq_word),
    .full      (fq_full),
    .pop       (bq_pop),
    .pop_word  (bq_word),
    .empty     (bq_empty)
  );

  // back: window, divider, result register
  sorw_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (bq_empty),
    .q_word    (bq_word),
    .q_pop     (bq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the send overshoot ratio window block.
// Random and directed feedback words go in, each result word is compared with
// a predictor of the window, and idling and stalls are varied by phase.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sorw_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [17:0] Q_MAX = 18'h3FFFF;
  localparam int QUIET_LIMIT = 10000;

  // Window predictor and store of expected result words.
  class ratio_board;
    logic [31:0] win_time [DEPTH];
    logic [47:0] win_bytes [DEPTH];
    logic [31:0] win_rate [DEPTH];
    int unsigned head, count;
    logic [63:0] bit_ms_sum;
    logic [31:0] newest_seq;
    logic [17:0] last_ratio;
    logic [15:0] span_ms;
    logic [9:0]  cap_pct;
    result_t     pending_words[$];
    int          mismatches;

    function new();
      head = 0; count = 0; bit_ms_sum = '0; newest_seq = '0; last_ratio = '0;
      span_ms = SPAN_RESET; cap_pct = CAP_RESET; mismatches = 0;
    endfunction

    function int unsigned slot(int unsigned k);
      return (head + k) % DEPTH;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == REG_SPAN) span_ms = val;
      else cap_pct = val[9:0];
    endfunction

    function void drop_oldest();
      int unsigned a, b;
      if (count >= 2) begin
        a = slot(0);
        b = slot(1);
        bit_ms_sum -= 64'(win_rate[b]) * 64'(win_time[b] - win_time[a]);
      end
      if (count > 0) begin
        head = (head + 1) % DEPTH;
        count--;
      end
      if (count <= 1) bit_ms_sum = '0;
    endfunction

    function logic [17:0] window_ratio();
      logic [47:0]  first_b, last_b, sent;
      logic [63:0]  den;
      logic [127:0] num, quo;
      logic [17:0]  q, cap;
      first_b = win_bytes[slot(0)];
      last_b  = win_bytes[slot(count - 1)];
      sent = (last_b >= first_b) ? last_b - first_b : '0;
      den = bit_ms_sum + BYTE_SCALE;
      num = 128'(sent) * 128'(RATIO_NUM);
      if (den == 0) q = Q_MAX;
      else begin
        quo = num / 128'(den);
        q = (quo > 128'(Q_MAX)) ? Q_MAX : quo[17:0];
      end
      cap = {cap_pct, 8'b0};
      return (q < cap) ? q : cap;
    endfunction

    function void note_word(item_t w);
      result_t r;
      logic [31:0] t, back;
      int unsigned s;
      if (w.sequence_number <= newest_seq) begin
        r.overshoot_ratio_q8 = last_ratio;
        r.ratio_updated = 1'b0;
      end else begin
        newest_seq = w.sequence_number;
        t = w.departure_ms;
        if (count >= DEPTH) drop_oldest();
        if (count > 0) begin
          back = win_time[slot(count - 1)];
          if (t < back) t = back;
          bit_ms_sum += 64'(w.target_rate_bps) * 64'(t - back);
        end
        s = slot(count);
        win_time[s] = t;
        win_bytes[s] = w.bytes_sent_total;
        win_rate[s] = w.target_rate_bps;
        count++;
        while (count > 1 && (t - win_time[slot(0)]) > 32'(span_ms)) drop_oldest();
        last_ratio = window_ratio();
        r.overshoot_ratio_q8 = last_ratio;
        r.ratio_updated = 1'b1;
      end
      pending_words.insert(pending_words.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        report("unexpected word", 32'(got.overshoot_ratio_q8), 32'd0);
        return;
      end
      want = pending_words[0];
      pending_words.delete(0);
      if (got.overshoot_ratio_q8 !== want.overshoot_ratio_q8)
        report("overshoot_ratio_q8", 32'(got.overshoot_ratio_q8),
               32'(want.overshoot_ratio_q8));
      if (got.ratio_updated !== want.ratio_updated)
        report("ratio_updated", 32'(got.ratio_updated), 32'(want.ratio_updated));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  item_t       in_word;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  result_t     out_word;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  send_overshoot_ratio_window_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_word(in_word), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ratio_board board = new();

  // idle percentages per side, pressure hold-off and activity for the watchdog
  int  send_idle_pct = 0;
  int  take_idle_pct = 0;
  bit  take_hold = 0;
  int  quiet_cycles = 0;

  // running stream state for well-formed record sequences
  logic [31:0] next_seq = 32'd0;
  logic [31:0] cur_time = 32'd0;
  logic [47:0] cur_bytes = 48'd0;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: pop decided at the falling edge, word checked at the rising edge.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = !take_hold && ($urandom_range(99) >= take_idle_pct);
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) board.check_word(out_word);
    end
  end

  // Offer one word, holding it until the block takes it.
  task send_word(item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_push = 1'b0;
    end
    @(negedge clk);
    in_push = 1'b1;
    in_word = w;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    board.note_word(w);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task wait_drained();
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, val);
  endtask

  // Build a word: mostly the next record of a plausible stream, sometimes noise.
  function item_t make_word();
    item_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // stale sequence, rejected unless it still beats the newest one seen; random fields toggle the high bits
      w.sequence_number = $urandom_range(0, next_seq);
      w.departure_ms = $urandom;
      w.bytes_sent_total = 48'({$urandom, $urandom});
      w.target_rate_bps = $urandom;
      return w;
    end
    next_seq += $urandom_range(1, 3);
    if ($urandom_range(99) < 5) cur_time = cur_time - $urandom_range(0, 500);
    else if ($urandom_range(1) == 0) cur_time += $urandom_range(0, 3);
    else cur_time += $urandom_range(0, 32'(board.span_ms) / 4 + 1);
    if ($urandom_range(99) < 3) cur_bytes = 48'({$urandom, $urandom});
    else cur_bytes += 48'($urandom_range(0, 1500));
    w.sequence_number = next_seq;
    w.departure_ms = cur_time;
    w.bytes_sent_total = cur_bytes;
    w.target_rate_bps = ($urandom_range(99) < 70) ? $urandom_range(0, 3000000) : $urandom;
    return w;
  endfunction

  task run_phase(int n, int s_idle, int t_idle);
    send_idle_pct = s_idle;
    take_idle_pct = t_idle;
    repeat (n) send_word(make_word());
  endtask

  task directed(logic [31:0] sq, logic [31:0] t, logic [47:0] b, logic [31:0] r);
    item_t w;
    w.sequence_number = sq;
    w.departure_ms = t;
    w.bytes_sent_total = b;
    w.target_rate_bps = r;
    send_word(w);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SPAN;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero sequence rejected after reset, extremes of every field,
    // backward time and byte count, repeated sequence, widest span, a 1000 percent cap.
    directed(32'd0, 32'd5, 48'd100, 32'd1000);
    write_reg(REG_SPAN, 16'hFFFF);
    write_reg(REG_CAP, 16'd1000);
    directed(32'd1, 32'd0, 48'd0, 32'd0);
    directed(32'd2, 32'd10, 48'd5000, 32'd8000);
    directed(32'd2, 32'd20, 48'd9000, 32'd8000);
    directed(32'd3, 32'd4, 48'd7000, 32'hFFFF_FFFF);
    directed(32'd4, 32'd30, 48'd1000, 32'd1000000);
    directed(32'd5, 32'd40, 48'hFFFF_FFFF_FFFF, 32'd0);
    directed(32'd6, 32'd100000, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    directed(32'd7, 32'hFFFF_FFFF, 48'd0, 32'd1);
    // zero span keeps only equal times; zero cap reads zero
    write_reg(REG_SPAN, 16'd0);
    directed(32'd8, 32'hFFFF_FFFF, 48'd200, 32'd500);
    directed(32'd9, 32'hFFFF_FFFF, 48'd900, 32'd500);
    write_reg(REG_CAP, 16'd0);
    directed(32'd10, 32'hFFFF_FFFF, 48'd2000, 32'd500);
    directed(32'd10, 32'hFFFF_FFFF, 48'd2000, 32'd500);

    // Random phases on a fresh stream, above the directed sequence numbers.
    next_seq = 32'h1000;
    cur_time = 32'd0;
    cur_bytes = 48'd0;
    write_reg(REG_SPAN, 16'd1);
    write_reg(REG_CAP, 16'd1);
    run_phase(10, 12, 69);

    write_reg(REG_SPAN, 16'd200);
    write_reg(REG_CAP, 16'd150);
    run_phase(600, 12, 69);
    write_reg(REG_SPAN, 16'd5000);
    write_reg(REG_CAP, 16'd600);
    run_phase(600, 69, 12);

    // No idling; the receiver first holds off long enough to fill the block.
    write_reg(REG_CAP, 16'd1000);
    fork
      begin
        take_hold = 1'b1;
        repeat (400) @(posedge clk);
        take_hold = 1'b0;
      end
    join_none
    run_phase(660, 0, 0);

    // top of the sequence range last, since nothing below it is taken after
    directed(32'hFFFF_FFF0, 32'd1, 48'd1, 32'd1);
    directed(32'hFFFF_FFF1, 32'd10, 48'd10, 32'd10);

    wait_drained();
    if (board.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
